>>> sv/mcsq_pkg.sv
// Shared types and constants for the two-wire memory card host sequencer.
// Used by mcsq_step and memory_card_two_wire_host_sequencer; no dependencies.
`timescale 1ns / 1ps

package mcsq_pkg;

  // Bytes read back after a card reset pulse
  localparam logic [2:0] ANSWER_BYTES = 3'd4;

  // Bits shifted out for opcode, address and data, and bits shifted in per read byte
  localparam logic [4:0] SEND_BITS = 5'd24;
  localparam logic [4:0] READ_BITS = 5'd8;

  // Configuration register reset values
  localparam logic [7:0] UPDATE_MAIN_RST       = 8'h38;
  localparam logic [7:0] UPDATE_PROTECTION_RST = 8'h3C;
  localparam logic [7:0] COMPARE_RST           = 8'h33;
  localparam logic [7:0] UPDATE_SECURITY_RST   = 8'h39;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_UPDATE_MAIN       = 2'd0,
    CFG_UPDATE_PROTECTION = 2'd1,
    CFG_COMPARE           = 2'd2,
    CFG_UPDATE_SECURITY   = 2'd3
  } cfg_index_e;

  // Request codes
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_COMMAND = 2'd1,
    REQ_READ    = 2'd2,
    REQ_RESET   = 2'd3
  } req_type_e;

  // Pin steps of the sequencer
  typedef enum logic [4:0] {
    ST_IDLE       = 5'd0,
    ST_S_CLKHIGH  = 5'd1,
    ST_S_IOLOW    = 5'd2,
    ST_B_CLKLOW   = 5'd3,
    ST_B_SETIO    = 5'd4,
    ST_B_CLKHIGH  = 5'd5,
    ST_P_CLKLOW   = 5'd6,
    ST_P_IOLOW    = 5'd7,
    ST_P_CLKHIGH  = 5'd8,
    ST_P_IOHIGH   = 5'd9,
    ST_W_RELEASE  = 5'd10,
    ST_W_CHECK    = 5'd11,
    ST_W_LOW      = 5'd12,
    ST_R_START    = 5'd13,
    ST_R_LOW      = 5'd14,
    ST_R_HIGH     = 5'd15,
    ST_R_SAMPLE   = 5'd16,
    ST_A_START    = 5'd17,
    ST_A_RSTHIGH  = 5'd18,
    ST_A_CLKHIGH  = 5'd19,
    ST_A_CLKLOW   = 5'd20,
    ST_A_RSTLOW   = 5'd21
  } step_e;

  // Sequencer state carried from beat to beat
  typedef struct packed {
    step_e       step;
    logic [4:0]  bit_count;
    logic [23:0] send_shift;
    logic [7:0]  receive_shift;
    logic [2:0]  answer_left;
    logic        clock_out;
    logic        data_out;
    logic        data_drive;
    logic        reset_out;
    logic        wait_proc;
  } seq_state_t;

  // Opcodes that need a processing wait
  typedef struct packed {
    logic [7:0] update_main;
    logic [7:0] update_protection;
    logic [7:0] compare;
    logic [7:0] update_security;
  } opcode_cfg_t;

  // One result beat
  typedef struct packed {
    logic       clk_level;
    logic       io_level;
    logic       io_drive;
    logic       rst_level;
    logic       busy_res;
    logic [7:0] read_value;
    logic       read_valid;
    logic       request_ignored;
  } result_t;

endpackage

>>> sv/mcsq_step.sv
// Combinational pin step: applies one request tick to the sequencer state.
// Depends on mcsq_pkg for the step enum and state/result structs.
`timescale 1ns / 1ps

module mcsq_step import mcsq_pkg::*; (
  input  seq_state_t  state_i,
  input  opcode_cfg_t opcodes_i,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  command_code_i,
  input  logic [7:0]  address_i,
  input  logic [7:0]  data_byte_i,
  input  logic        io_sample_i,
  output seq_state_t  state_o,
  output result_t     result_o
);

  seq_state_t st_a;
  logic       ignored;
  logic [4:0] bit_inc;
  logic [7:0] recv_next;
  logic [2:0] ans_dec;
  step_e      step_d;

  // Take a new request while idle, drop it while busy
  always_comb begin
    st_a    = state_i;
    ignored = 1'b0;
    if (req_type_i != REQ_TICK) begin
      if (state_i.step != ST_IDLE) begin
        ignored = 1'b1;
      end else begin
        case (req_type_e'(req_type_i))
          REQ_COMMAND: begin
            st_a.send_shift = {data_byte_i, address_i, command_code_i};
            st_a.bit_count  = 5'd0;
            st_a.wait_proc  = (command_code_i == opcodes_i.update_main) ||
                              (command_code_i == opcodes_i.update_protection) ||
                              (command_code_i == opcodes_i.compare) ||
                              (command_code_i == opcodes_i.update_security);
            st_a.step       = ST_S_CLKHIGH;
          end
          REQ_READ: begin
            st_a.answer_left = 3'd0;
            st_a.step        = ST_R_START;
          end
          REQ_RESET: begin
            st_a.answer_left = 3'd0;
            st_a.step        = ST_A_START;
          end
          default: ;
        endcase
      end
    end
  end

  assign bit_inc   = 5'(st_a.bit_count + 5'd1);
  assign recv_next = {io_sample_i, st_a.receive_shift[7:1]};
  assign ans_dec   = (st_a.answer_left != 3'd0) ? 3'(st_a.answer_left - 3'd1) : 3'd0;

  // Next step
  always_comb begin
    case (st_a.step)
      ST_IDLE:      step_d = ST_IDLE;
      ST_S_CLKHIGH: step_d = ST_S_IOLOW;
      ST_S_IOLOW:   step_d = ST_B_CLKLOW;
      ST_B_CLKLOW:  step_d = ST_B_SETIO;
      ST_B_SETIO:   step_d = ST_B_CLKHIGH;
      ST_B_CLKHIGH: step_d = (bit_inc >= SEND_BITS) ? ST_P_CLKLOW : ST_B_CLKLOW;
      ST_P_CLKLOW:  step_d = ST_P_IOLOW;
      ST_P_IOLOW:   step_d = ST_P_CLKHIGH;
      ST_P_CLKHIGH: step_d = ST_P_IOHIGH;
      ST_P_IOHIGH:  step_d = st_a.wait_proc ? ST_W_RELEASE : ST_IDLE;
      ST_W_RELEASE: step_d = ST_W_CHECK;
      ST_W_CHECK:   step_d = io_sample_i ? ST_IDLE : ST_W_LOW;
      ST_W_LOW:     step_d = ST_W_CHECK;
      ST_R_START:   step_d = ST_R_LOW;
      ST_R_LOW:     step_d = ST_R_HIGH;
      ST_R_HIGH:    step_d = ST_R_SAMPLE;
      ST_R_SAMPLE: begin
        if (bit_inc >= READ_BITS) begin
          step_d = (ans_dec != 3'd0) ? ST_R_START : ST_IDLE;
        end else begin
          step_d = ST_R_HIGH;
        end
      end
      ST_A_START:   step_d = ST_A_RSTHIGH;
      ST_A_RSTHIGH: step_d = ST_A_CLKHIGH;
      ST_A_CLKHIGH: step_d = ST_A_CLKLOW;
      ST_A_CLKLOW:  step_d = ST_A_RSTLOW;
      ST_A_RSTLOW:  step_d = (ANSWER_BYTES != 3'd0) ? ST_R_START : ST_IDLE;
      default:      step_d = ST_IDLE;
    endcase
  end

  // Pin levels, shifters and the result beat
  always_comb begin
    state_o                  = st_a;
    state_o.step             = step_d;
    result_o                 = '0;
    result_o.request_ignored = ignored;
    case (st_a.step)
      ST_S_CLKHIGH: state_o.clock_out = 1'b1;
      ST_S_IOLOW: begin
        state_o.data_drive = 1'b1;
        state_o.data_out   = 1'b0;
        state_o.bit_count  = 5'd0;
      end
      ST_B_CLKLOW:  state_o.clock_out = 1'b0;
      ST_B_SETIO: begin
        state_o.data_out   = st_a.send_shift[0];
        state_o.send_shift = {1'b0, st_a.send_shift[23:1]};
      end
      ST_B_CLKHIGH: begin
        state_o.clock_out = 1'b1;
        state_o.bit_count = bit_inc;
      end
      ST_P_CLKLOW:  state_o.clock_out = 1'b0;
      ST_P_IOLOW:   state_o.data_out  = 1'b0;
      ST_P_CLKHIGH: state_o.clock_out = 1'b1;
      ST_P_IOHIGH:  state_o.data_out  = 1'b1;
      ST_W_RELEASE: begin
        state_o.data_drive = 1'b0;
        state_o.clock_out  = 1'b0;
      end
      ST_W_CHECK: begin
        if (io_sample_i) begin
          state_o.wait_proc = 1'b0;
        end else begin
          state_o.clock_out = 1'b1;
        end
      end
      ST_W_LOW:     state_o.clock_out = 1'b0;
      ST_R_START: begin
        state_o.data_drive    = 1'b0;
        state_o.clock_out     = 1'b1;
        state_o.bit_count     = 5'd0;
        state_o.receive_shift = 8'd0;
      end
      ST_R_LOW:     state_o.clock_out = 1'b0;
      ST_R_HIGH:    state_o.clock_out = 1'b1;
      ST_R_SAMPLE: begin
        state_o.receive_shift = recv_next;
        state_o.bit_count     = bit_inc;
        if (bit_inc >= READ_BITS) begin
          result_o.read_value = recv_next;
          result_o.read_valid = 1'b1;
          state_o.answer_left = ans_dec;
        end else begin
          state_o.clock_out = 1'b0;
        end
      end
      ST_A_START: begin
        state_o.data_drive = 1'b0;
        state_o.reset_out  = 1'b0;
        state_o.clock_out  = 1'b0;
      end
      ST_A_RSTHIGH: state_o.reset_out = 1'b1;
      ST_A_CLKHIGH: state_o.clock_out = 1'b1;
      ST_A_CLKLOW:  state_o.clock_out = 1'b0;
      ST_A_RSTLOW: begin
        state_o.reset_out   = 1'b0;
        state_o.answer_left = ANSWER_BYTES;
      end
      default: ;
    endcase
    result_o.clk_level = state_o.clock_out;
    result_o.io_level  = state_o.data_out;
    result_o.io_drive  = state_o.data_drive;
    result_o.rst_level = state_o.reset_out;
    result_o.busy_res  = (step_d != ST_IDLE);
  end

endmodule

>>> sv/memory_card_two_wire_host_sequencer.sv
// Top level: input register, sequencer state, opcode registers, result register.
// Depends on mcsq_pkg and mcsq_step.
// Path: input register, the single combinational pin step, result register.
// Throughput: one tick beat per cycle, less while out_stall_i holds the output.
// Reset (rst_ni low, asynchronous): sequencer idle, pins low, IO released,
//   opcode registers back to their defaults, both pipeline stages empty.
`timescale 1ns / 1ps

module memory_card_two_wire_host_sequencer import mcsq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // tick channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] command_code_i,
  input  logic [7:0] address_i,
  input  logic [7:0] data_byte_i,
  input  logic       io_sample_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       clk_level_o,
  output logic       io_level_o,
  output logic       io_drive_o,
  output logic       rst_level_o,
  output logic       busy_res_o,
  output logic [7:0] read_value_o,
  output logic       read_valid_o,
  output logic       request_ignored_o,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic        in_valid_q;
  logic [1:0]  req_type_q;
  logic [7:0]  command_code_q;
  logic [7:0]  address_q;
  logic [7:0]  data_byte_q;
  logic        io_sample_q;
  logic        out_valid_q;
  logic        out_free;
  logic        advance;
  seq_state_t  state_q;
  seq_state_t  state_d;
  opcode_cfg_t opcodes_q;
  result_t     result_d;
  result_t     result_q;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign cfg_ready_o = 1'b1;

  // Opcode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opcodes_q.update_main       <= UPDATE_MAIN_RST;
      opcodes_q.update_protection <= UPDATE_PROTECTION_RST;
      opcodes_q.compare           <= COMPARE_RST;
      opcodes_q.update_security   <= UPDATE_SECURITY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_UPDATE_MAIN:       opcodes_q.update_main       <= cfg_data_i;
        CFG_UPDATE_PROTECTION: opcodes_q.update_protection <= cfg_data_i;
        CFG_COMPARE:           opcodes_q.compare           <= cfg_data_i;
        CFG_UPDATE_SECURITY:   opcodes_q.update_security   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage: hold the beat while the result side is full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_type_q     <= req_type_i;
      command_code_q <= command_code_i;
      address_q      <= address_i;
      data_byte_q    <= data_byte_i;
      io_sample_q    <= io_sample_i;
    end
  end

  mcsq_step u_step (
    .state_i        (state_q),
    .opcodes_i      (opcodes_q),
    .req_type_i     (req_type_q),
    .command_code_i (command_code_q),
    .address_i      (address_q),
    .data_byte_i    (data_byte_q),
    .io_sample_i    (io_sample_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  // Sequencer state: advance one pin step per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{step: ST_IDLE, default: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign clk_level_o       = result_q.clk_level;
  assign io_level_o        = result_q.io_level;
  assign io_drive_o        = result_q.io_drive;
  assign rst_level_o       = result_q.rst_level;
  assign busy_res_o        = result_q.busy_res;
  assign read_value_o      = result_q.read_value;
  assign read_valid_o      = result_q.read_valid;
  assign request_ignored_o = result_q.request_ignored;

  // Read byte stays zero unless it completes on this beat
  a_read_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_value_o == 8'd0)
    else $error("read_value nonzero without read_valid");

  // A request is dropped only while a sequence runs
  a_ignore_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q.step == ST_IDLE |-> !result_d.request_ignored)
    else $error("request dropped while idle");

  // Card reset line is high only inside the reset pulse
  a_rst_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.reset_out |-> state_q.step == ST_A_CLKHIGH ||
                          state_q.step == ST_A_CLKLOW ||
                          state_q.step == ST_A_RSTLOW)
    else $error("reset line high outside reset pulse");

  // Sequencer state moves only on an advancing beat
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a beat");

endmodule
